@@ rtl/core/lpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Shared types, codes and default constants for the deframer blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    localparam int unsigned MAX_LIMIT_DEF     = 32'd16777216;
    localparam int unsigned DEFAULT_LIMIT_DEF = 32'd1048576;
    localparam int          LEN_W_DEF         = 25;
    localparam int          CFG_W             = 32;
    localparam int          PEND_W            = 25;
    localparam int          SHIFT_W           = 24;
    localparam int          HEADER_LEN        = 4;

    localparam logic CMD_STREAM   = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;
    localparam logic ERR_ZERO_LEN = 1'b0;
    localparam logic ERR_TOO_LONG = 1'b1;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_DROP    = 2'd2
    } mode_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [7:0]        payload_byte;
        logic              frame_last;
        logic              error_code;
        logic [PEND_W-1:0] pending_bytes;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/lpd_limit.sv @@
// ----------------------------------------------------------------------------
// Effective limit register
// Clamps the written limit, maps zero to the default, holds the payload limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_limit #(
    parameter int unsigned MAX_LIMIT     = lpd_pkg::MAX_LIMIT_DEF,
    parameter int unsigned DEFAULT_LIMIT = lpd_pkg::DEFAULT_LIMIT_DEF,
    parameter int          LEN_W         = lpd_pkg::LEN_W_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lpd_pkg::CFG_W-1:0]  cfg_wr_data,
    output logic      [LEN_W-1:0]           eff_limit
);

    logic [LEN_W-1:0] limit_reg;
    logic [LEN_W-1:0] limit_next;

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            limit_next = LEN_W'(DEFAULT_LIMIT);
        end
        else if (cfg_wr_data > lpd_pkg::CFG_W'(MAX_LIMIT))
        begin
            limit_next = LEN_W'(MAX_LIMIT);
        end
        else
        begin
            limit_next = cfg_wr_data[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LEN_W'(DEFAULT_LIMIT);
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= limit_next;
        end
    end

    assign eff_limit = limit_reg;

endmodule

`default_nettype wire

@@ rtl/core/lpd_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser
// Header collection, length check, payload pass-through and error drop.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_parser #(
    parameter int LEN_W = lpd_pkg::LEN_W_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire lpd_pkg::in_item_t item,
    input  wire logic [LEN_W-1:0]  eff_limit,
    output lpd_pkg::result_t       result
);

    localparam int WIDE_W = (LEN_W + 2 > lpd_pkg::PEND_W) ? LEN_W + 2 : lpd_pkg::PEND_W;

    lpd_pkg::mode_t                 mode_reg, mode_next;
    logic [1:0]                     hdr_cnt_reg, hdr_cnt_next;
    logic [lpd_pkg::SHIFT_W-1:0]    hdr_shift_reg, hdr_shift_next;
    logic [LEN_W-1:0]               frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]               remaining_reg, remaining_next;

    logic [lpd_pkg::CFG_W-1:0]      len_full;
    logic [LEN_W-1:0]               rem_dec;
    logic [WIDE_W-1:0]              pend_wide;

    always_comb
    begin
        len_full = {hdr_shift_reg, item.data_byte};
        rem_dec  = (remaining_reg != '0) ? remaining_reg - LEN_W'(1) : remaining_reg;
        pend_wide = WIDE_W'(frame_len_reg) - WIDE_W'(rem_dec)
                  + WIDE_W'(lpd_pkg::HEADER_LEN);

        mode_next      = mode_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_shift_next = hdr_shift_reg;
        frame_len_next = frame_len_reg;
        remaining_next = remaining_reg;
        result         = '0;

        if (item.cmd == lpd_pkg::CMD_CLEAR)
        begin
            mode_next      = lpd_pkg::MODE_HEADER;
            hdr_cnt_next   = '0;
            hdr_shift_next = '0;
            frame_len_next = '0;
            remaining_next = '0;
        end
        else
        begin
            case (mode_reg)
                lpd_pkg::MODE_DROP:
                begin
                    if (item.chunk_end)
                    begin
                        mode_next      = lpd_pkg::MODE_HEADER;
                        hdr_cnt_next   = '0;
                        hdr_shift_next = '0;
                        frame_len_next = '0;
                        remaining_next = '0;
                    end
                end
                lpd_pkg::MODE_PAYLOAD:
                begin
                    result.valid             = 1'b1;
                    result.item.result_kind  = lpd_pkg::KIND_PAYLOAD;
                    result.item.payload_byte = item.data_byte;
                    if (rem_dec == '0)
                    begin
                        result.item.frame_last = 1'b1;
                        mode_next              = lpd_pkg::MODE_HEADER;
                        hdr_cnt_next           = '0;
                        hdr_shift_next         = '0;
                        frame_len_next         = '0;
                        remaining_next         = '0;
                    end
                    else
                    begin
                        result.item.pending_bytes = pend_wide[lpd_pkg::PEND_W-1:0];
                        remaining_next            = rem_dec;
                    end
                end
                default:
                begin
                    mode_next = lpd_pkg::MODE_HEADER;
                    if (hdr_cnt_reg != 2'd3)
                    begin
                        hdr_shift_next = len_full[lpd_pkg::SHIFT_W-1:0];
                        hdr_cnt_next   = hdr_cnt_reg + 2'd1;
                    end
                    else if (len_full == '0
                             || len_full > lpd_pkg::CFG_W'(eff_limit))
                    begin
                        result.valid            = 1'b1;
                        result.item.result_kind = lpd_pkg::KIND_ERROR;
                        result.item.error_code  = (len_full == '0) ?
                            lpd_pkg::ERR_ZERO_LEN : lpd_pkg::ERR_TOO_LONG;
                        mode_next      = item.chunk_end ?
                            lpd_pkg::MODE_HEADER : lpd_pkg::MODE_DROP;
                        hdr_cnt_next   = '0;
                        hdr_shift_next = '0;
                        frame_len_next = '0;
                        remaining_next = '0;
                    end
                    else
                    begin
                        mode_next      = lpd_pkg::MODE_PAYLOAD;
                        hdr_cnt_next   = '0;
                        hdr_shift_next = '0;
                        frame_len_next = len_full[LEN_W-1:0];
                        remaining_next = len_full[LEN_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lpd_pkg::MODE_HEADER;
            hdr_cnt_reg   <= '0;
            hdr_shift_reg <= '0;
            frame_len_reg <= '0;
            remaining_reg <= '0;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            hdr_shift_reg <= hdr_shift_next;
            frame_len_reg <= frame_len_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lpd_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result for the output channel and sets input flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire lpd_pkg::result_t   result,
    input  wire logic               out_ready,
    output logic                    space,
    output logic                    out_valid,
    output lpd_pkg::out_item_t      out_data
);

    logic               valid_reg, valid_next;
    lpd_pkg::out_item_t data_reg;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (take && result.valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && result.valid)
        begin
            data_reg <= result.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/length_prefixed_deframer.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed deframer
// Splits a byte stream into frames with a 4-byte big-endian length header.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle, a stream byte or a clear
// command, whenever the result register is empty or being read in the same
// cycle. Each request is handled combinationally by the parser and its result,
// if any, appears in the result register on the next cycle. Header bytes,
// dropped bytes and clear commands produce no result; payload bytes and
// framing errors produce one.
`default_nettype none

module length_prefixed_deframer #(
    parameter int unsigned MAX_LIMIT     = lpd_pkg::MAX_LIMIT_DEF,
    parameter int unsigned DEFAULT_LIMIT = lpd_pkg::DEFAULT_LIMIT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lpd_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire lpd_pkg::in_item_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output lpd_pkg::out_item_t              out_data
);

    localparam int unsigned LIM_TOP = (MAX_LIMIT > DEFAULT_LIMIT) ? MAX_LIMIT : DEFAULT_LIMIT;
    localparam int          LEN_W   = $clog2(64'(LIM_TOP) + 64'd1);

    logic             take;
    logic [LEN_W-1:0] eff_limit;
    lpd_pkg::result_t result;

    assign take = in_valid && in_ready;

    lpd_limit #(
        .MAX_LIMIT     (MAX_LIMIT),
        .DEFAULT_LIMIT (DEFAULT_LIMIT),
        .LEN_W         (LEN_W)
    ) u_limit (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .eff_limit   (eff_limit)
    );

    lpd_parser #(
        .LEN_W (LEN_W)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (in_data),
        .eff_limit (eff_limit),
        .result    (result)
    );

    lpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .result    (result),
        .out_ready (out_ready),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("Input accepted while a result is stalled.");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_data.cmd == lpd_pkg::CMD_CLEAR
        |=> out_valid == ($past(out_valid) && !$past(out_ready)))
        else $error("A clear request produced a result.");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == lpd_pkg::KIND_ERROR
        |-> out_data.pending_bytes == '0 && !out_data.frame_last)
        else $error("Error result carries payload state.");

    a_last_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_last |-> out_data.pending_bytes == '0)
        else $error("Final payload byte reports pending bytes.");

endmodule

`default_nettype wire
